FILE: hw/rtl/bfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_pkg
// Types and constants shared by the stages of the bfloat16 exponential unit.
// ----------------------------------------------------------------------------
package bfe_pkg;

	localparam int FRAC  = 52;
	localparam int XW    = 59;
	localparam int PW    = 53;
	localparam int RW    = 52;
	localparam int KW    = 8;
	localparam int ORDER = 13;

	typedef logic [15:0]   bf16_t;
	typedef logic [PW-1:0] poly_t;

	typedef struct packed {
		logic          fixed;
		bf16_t         fixed_val;
		logic          xneg;
		logic [KW-1:0] km;
		logic          last;
	} side_t;

	typedef enum logic {
		REG_COLUMNS = 1'b0,
		REG_ROWS    = 1'b1
	} reg_idx_t;

	localparam bf16_t       BF_INF    = 16'h7F80;
	localparam bf16_t       BF_ZERO   = 16'h0000;
	localparam bf16_t       QNAN_BIT  = 16'h0040;
	localparam logic [14:0] X_MAX     = 15'h42B2;
	localparam logic [14:0] X_MIN_MAG = 15'h42D0;
	localparam logic [16:0] LOG2E     = 17'h17154;
	localparam logic [55:0] LN2       = 56'hB17217F7D1CF79;

	localparam poly_t COEF [ORDER+1] = '{
		poly_t'((64'd1 << FRAC) / 64'd1),
		poly_t'((64'd1 << FRAC) / 64'd1),
		poly_t'((64'd1 << FRAC) / 64'd2),
		poly_t'((64'd1 << FRAC) / 64'd6),
		poly_t'((64'd1 << FRAC) / 64'd24),
		poly_t'((64'd1 << FRAC) / 64'd120),
		poly_t'((64'd1 << FRAC) / 64'd720),
		poly_t'((64'd1 << FRAC) / 64'd5040),
		poly_t'((64'd1 << FRAC) / 64'd40320),
		poly_t'((64'd1 << FRAC) / 64'd362880),
		poly_t'((64'd1 << FRAC) / 64'd3628800),
		poly_t'((64'd1 << FRAC) / 64'd39916800),
		poly_t'((64'd1 << FRAC) / 64'd479001600),
		poly_t'((64'd1 << FRAC) / 64'd6227020800)
	};

endpackage

FILE: hw/rtl/bf16_exponential_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_exponential_unit
// Natural exponential of a stream of bfloat16 words with end-of-matrix flag.
// ----------------------------------------------------------------------------
// The unit takes one word per cycle while no result is stalled at the output.
// Each word passes through argument reduction, a multiply stage and an
// accumulate stage for each of the thirteen Horner steps of the series,
// and scaling and rounding. The whole pipeline advances together and holds
// while a result is stalled at the output, so the input is stalled only then.
module bf16_exponential_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                value_valid,
	output logic                value_stall,
	input  bfe_pkg::bf16_t      value,
	output logic                result_valid,
	input  logic                result_stall,
	output bfe_pkg::bf16_t      result,
	output logic                last
);
	import bfe_pkg::*;

	logic [15:0] column_count_q;
	logic [15:0] row_count_q;
	logic [15:0] inner_q;
	logic [15:0] outer_q;
	logic [16:0] cols;
	logic [16:0] rows;
	logic        inner_end;
	logic        outer_end;
	logic        accept;
	logic        adv;
	reg_idx_t    idx;

	logic          red_valid;
	side_t         red_side;
	logic          red_rneg;
	logic [RW-1:0] red_rmag;
	logic          poly_valid;
	side_t         poly_side;
	poly_t         poly_p;

	assign adv         = !(result_valid && result_stall);
	assign value_stall = !adv;
	assign accept      = value_valid && adv;
	assign pready      = 1'b1;
	assign idx         = reg_idx_t'(paddr[2]);

	always_comb begin
		cols      = (column_count_q == 16'd0) ? 17'd1 : 17'(column_count_q);
		rows      = (row_count_q == 16'd0) ? 17'd1 : 17'(row_count_q);
		inner_end = (17'(inner_q) + 17'd1) >= cols;
		outer_end = (17'(outer_q) + 17'd1) >= rows;
		unique case (idx)
			REG_COLUMNS: prdata = 32'(column_count_q);
			REG_ROWS:    prdata = 32'(row_count_q);
			default:     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= 16'd1;
			row_count_q    <= 16'd1;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_COLUMNS: column_count_q <= pwdata[15:0];
				REG_ROWS:    row_count_q    <= pwdata[15:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= 16'd0;
			outer_q <= 16'd0;
		end else if (accept) begin
			if (inner_end) begin
				inner_q <= 16'd0;
				outer_q <= outer_end ? 16'd0 : (outer_q + 16'd1);
			end else begin
				inner_q <= inner_q + 16'd1;
			end
		end
	end

	bfe_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (accept),
		.value    (value),
		.in_last  (inner_end && outer_end),
		.out_valid(red_valid),
		.out_side (red_side),
		.out_rneg (red_rneg),
		.out_rmag (red_rmag)
	);

	bfe_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (red_valid),
		.in_side  (red_side),
		.in_rneg  (red_rneg),
		.in_rmag  (red_rmag),
		.out_valid(poly_valid),
		.out_side (poly_side),
		.out_p    (poly_p)
	);

	bfe_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (poly_valid),
		.in_side   (poly_side),
		.in_p      (poly_p),
		.out_valid (result_valid),
		.out_result(result),
		.out_last  (last)
	);

`ifndef SYNTHESIS
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && inner_end && outer_end) |=> (inner_q == 16'd0 && outer_q == 16'd0))
		else $error("Counters did not wrap after the last word of the matrix.");

	a_inner_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !inner_end) |=> (inner_q == $past(inner_q) + 16'd1))
		else $error("Inner counter did not advance by one.");

	a_nan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result[14:7] == 8'hFF && result[6:0] != 7'd0) |-> result[6])
		else $error("A NaN result left the unit without its quiet bit.");
`endif

endmodule

FILE: hw/rtl/bfe_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_reduce
// Decodes the word, flags special values and reduces the argument so that
// exp(x) = 2^k * exp(r) with a small remainder r.
// ----------------------------------------------------------------------------
module bfe_reduce (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  bfe_pkg::bf16_t      value,
	input  logic                in_last,
	output logic                out_valid,
	output bfe_pkg::side_t      out_side,
	output logic                out_rneg,
	output logic [bfe_pkg::RW-1:0] out_rmag
);
	import bfe_pkg::*;

	logic [7:0]    e;
	logic [7:0]    sig;
	logic [XW-1:0] xm;
	side_t         side_in;
	side_t         side_k;
	logic [40:0]   ksum;
	logic [63:0]   kln2;
	logic [60:0]   diff;
	logic [60:0]   dabs;

	logic          valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	side_t         side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [XW-1:0] xm_s1, xm_s2, xm_s3, xm_s4, xm_s5;
	logic [39:0]   tprod_s2;
	logic [35:0]   khi_s4, klo_s4;
	logic [63:0]   kln2_s5;
	side_t         side_s6;
	logic          rneg_s6;
	logic [RW-1:0] rmag_s6;

	always_comb begin
		e   = value[14:7];
		sig = {e != 8'd0, value[6:0]};
		if (e >= 8'd82) begin
			xm = XW'(sig) << (e - 8'd82);
		end else begin
			xm = XW'(sig) >> (8'd82 - e);
		end
		side_in.xneg      = value[15];
		side_in.km        = '0;
		side_in.last      = in_last;
		side_in.fixed     = 1'b1;
		if (e == 8'hFF && value[6:0] != 7'd0) begin
			side_in.fixed_val = value | QNAN_BIT;
		end else if (!value[15] && value[14:0] > X_MAX) begin
			side_in.fixed_val = BF_INF;
		end else if (value[15] && value[14:0] > X_MIN_MAG) begin
			side_in.fixed_val = BF_ZERO;
		end else begin
			side_in.fixed     = 1'b0;
			side_in.fixed_val = BF_ZERO;
		end
		ksum      = {1'b0, tprod_s2} + 41'h00080000000;
		side_k    = side_s2;
		side_k.km = ksum[39:32];
		kln2 = (64'(khi_s4) << 28) + 64'(klo_s4);
		diff = 61'(xm_s5) - 61'(kln2_s5[63:4]);
		dabs = diff[60] ? (61'd0 - diff) : diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1  <= side_in;
			xm_s1    <= xm;
			side_s2  <= side_s1;
			xm_s2    <= xm_s1;
			tprod_s2 <= 40'(xm_s1[XW-1 -: 23]) * 40'(LOG2E);
			side_s3  <= side_k;
			xm_s3    <= xm_s2;
			side_s4  <= side_s3;
			xm_s4    <= xm_s3;
			khi_s4   <= 36'(side_s3.km) * 36'(LN2[55:28]);
			klo_s4   <= 36'(side_s3.km) * 36'(LN2[27:0]);
			side_s5  <= side_s4;
			xm_s5    <= xm_s4;
			kln2_s5  <= kln2;
			side_s6  <= side_s5;
			rneg_s6  <= diff[60] ^ side_s5.xneg;
			rmag_s6  <= dabs[RW-1:0];
		end
	end

	assign out_valid = valid_s6;
	assign out_side  = side_s6;
	assign out_rneg  = rneg_s6;
	assign out_rmag  = rmag_s6;

endmodule

FILE: hw/rtl/bfe_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_poly
// Evaluates the Taylor series of exp(r) by Horner's rule, one multiply stage
// and one accumulate stage for each coefficient below the leading one.
// ----------------------------------------------------------------------------
module bfe_poly (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  bfe_pkg::side_t         in_side,
	input  logic                   in_rneg,
	input  logic [bfe_pkg::RW-1:0] in_rmag,
	output logic                   out_valid,
	output bfe_pkg::side_t         out_side,
	output bfe_pkg::poly_t         out_p
);
	import bfe_pkg::*;

	logic          vin  [ORDER];
	side_t         sin  [ORDER];
	logic          rnin [ORDER];
	logic [RW-1:0] rmin [ORDER];
	poly_t         pin  [ORDER];
	logic [104:0]  sum  [ORDER];
	poly_t         pnext[ORDER];

	logic          valid_s1 [ORDER];
	side_t         side_s1  [ORDER];
	logic          rneg_s1  [ORDER];
	logic [RW-1:0] rmag_s1  [ORDER];
	logic [52:0]   hh_s1    [ORDER];
	logic [52:0]   hl_s1    [ORDER];
	logic [51:0]   lh_s1    [ORDER];
	logic [51:0]   ll_s1    [ORDER];
	logic          valid_s2 [ORDER];
	side_t         side_s2  [ORDER];
	logic          rneg_s2  [ORDER];
	logic [RW-1:0] rmag_s2  [ORDER];
	poly_t         p_s2     [ORDER];

	always_comb begin
		for (int j = 0; j < ORDER; j++) begin
			if (j == 0) begin
				vin[j]  = in_valid;
				sin[j]  = in_side;
				rnin[j] = in_rneg;
				rmin[j] = in_rmag;
				pin[j]  = COEF[ORDER];
			end else begin
				vin[j]  = valid_s2[j-1];
				sin[j]  = side_s2[j-1];
				rnin[j] = rneg_s2[j-1];
				rmin[j] = rmag_s2[j-1];
				pin[j]  = p_s2[j-1];
			end
			sum[j] = (105'(hh_s1[j]) << 52) + ((105'(hl_s1[j]) + 105'(lh_s1[j])) << 26)
				+ 105'(ll_s1[j]);
			if (rneg_s1[j]) begin
				pnext[j] = COEF[ORDER-1-j] - sum[j][104:52];
			end else begin
				pnext[j] = COEF[ORDER-1-j] + sum[j][104:52];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < ORDER; j++) begin
				valid_s1[j] <= 1'b0;
				valid_s2[j] <= 1'b0;
			end
		end else if (adv) begin
			for (int j = 0; j < ORDER; j++) begin
				valid_s1[j] <= vin[j];
				valid_s2[j] <= valid_s1[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < ORDER; j++) begin
				side_s1[j] <= sin[j];
				rneg_s1[j] <= rnin[j];
				rmag_s1[j] <= rmin[j];
				hh_s1[j]   <= 53'(pin[j][52:26]) * 53'(rmin[j][51:26]);
				hl_s1[j]   <= 53'(pin[j][52:26]) * 53'(rmin[j][25:0]);
				lh_s1[j]   <= 52'(pin[j][25:0]) * 52'(rmin[j][51:26]);
				ll_s1[j]   <= 52'(pin[j][25:0]) * 52'(rmin[j][25:0]);
				side_s2[j] <= side_s1[j];
				rneg_s2[j] <= rneg_s1[j];
				rmag_s2[j] <= rmag_s1[j];
				p_s2[j]    <= pnext[j];
			end
		end
	end

	assign out_valid = valid_s2[ORDER-1];
	assign out_side  = side_s2[ORDER-1];
	assign out_p     = p_s2[ORDER-1];

endmodule

FILE: hw/rtl/bfe_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_pack
// Scales exp(r) by 2^k, rounds to single precision with subnormals and then
// to bfloat16, both to nearest even.
// ----------------------------------------------------------------------------
module bfe_pack (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  bfe_pkg::side_t in_side,
	input  bfe_pkg::poly_t in_p,
	output logic           out_valid,
	output bfe_pkg::bf16_t out_result,
	output logic           out_last
);
	import bfe_pkg::*;

	logic signed [9:0] k;
	logic signed [9:0] ex;
	logic signed [9:0] fe;
	logic [5:0]        sh;
	logic [8:0]        base;
	poly_t             m;
	poly_t             mask;
	poly_t             keep;
	logic              lost;
	logic              rup;
	logic [31:0]       u;
	logic [31:0]       ur;
	bf16_t             res;

	logic        valid_s1, valid_s2, valid_s3;
	side_t       side_s1, side_s2;
	poly_t       m_s1;
	logic [5:0]  sh_s1;
	logic [8:0]  base_s1, base_s2;
	logic [23:0] mant_s2;
	logic        rup_s2;
	bf16_t       result_s3;
	logic        last_s3;

	always_comb begin
		k  = in_side.xneg ? (10'sd0 - $signed({2'b00, in_side.km}))
			: $signed({2'b00, in_side.km});
		ex = in_p[PW-1] ? k : (k - 10'sd1);
		m  = in_p[PW-1] ? in_p : (in_p << 1);
		fe = ex + 10'sd127;
		if (fe >= 10'sd1) begin
			sh   = 6'd0;
			base = 9'(fe - 10'sd1);
		end else begin
			sh   = 6'(10'sd1 - fe);
			base = 9'd0;
		end
		mask = ~({PW{1'b1}} << sh_s1);
		keep = m_s1 >> sh_s1;
		lost = (|(m_s1 & mask)) | (|keep[27:0]);
		rup  = keep[28] & (lost | keep[29]);
		u    = (32'(base_s2) << 23) + 32'(mant_s2) + 32'(rup_s2);
		ur   = u + 32'h00007FFF + 32'(u[16]);
		if (side_s2.fixed) begin
			res = side_s2.fixed_val;
		end else if (u >= 32'h7F800000) begin
			res = BF_INF;
		end else begin
			res = ur[31:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1   <= in_side;
			m_s1      <= m;
			sh_s1     <= sh;
			base_s1   <= base;
			side_s2   <= side_s1;
			base_s2   <= base_s1;
			mant_s2   <= keep[52:29];
			rup_s2    <= rup;
			result_s3 <= res;
			last_s3   <= side_s2.last;
		end
	end

	assign out_valid  = valid_s3;
	assign out_result = result_s3;
	assign out_last   = last_s3;

endmodule

FILE: tb/tb_bf16_exponential_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bf16_exponential_unit
// Self-checking bench for the bfloat16 exponential unit. Words are driven on
// the value channel and every result word is checked against an in-bench
// double-precision model of exp() with both roundings, along with the
// end-of-matrix flag worked out from the configured column and row counts.
// ----------------------------------------------------------------------------
module tb_bf16_exponential_unit;
	import bfe_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 3000;

	typedef struct {
		bf16_t result;
		logic  last;
	} exp_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        value_valid = 1'b0;
	logic        value_stall;
	bf16_t       value = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	bf16_t       result;
	logic        last;

	exp_word_t   pending_q[$];
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          errors = 0;
	int          words_in = 0;
	int          words_out = 0;
	int          lasts_seen = 0;
	logic [15:0] cols_cfg = 16'd1;
	logic [15:0] rows_cfg = 16'd1;
	logic [15:0] inner_idx = '0;
	logic [15:0] outer_idx = '0;

	bf16_exponential_unit u_dut (.*);

	always #2 clk = ~clk;

	// Double to single precision, round to nearest even, subnormals kept.
	function automatic logic [31:0] to_single(input real d);
		logic [63:0] db;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		int          e;
		int          sh;
		db = $realtobits(d);
		e  = int'(db[62:52]);
		if (e >= 897) begin
			q    = (64'(e - 896) << 23) | 64'(db[51:29]);
			rem  = 64'(db[28:0]);
			half = 64'd1 << 28;
		end else begin
			sh = 926 - e;
			if (sh >= 54)
				return 32'd0;
			q    = {12'd1, db[51:0]} >> sh;
			rem  = {12'd1, db[51:0]} & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
		end
		if (rem > half || (rem == half && q[0]))
			q = q + 64'd1;
		return q[31:0];
	endfunction

	function automatic bf16_t bf16_exp(input bf16_t in);
		real         x;
		real         t;
		real         r;
		real         p;
		real         d;
		int          k;
		logic [31:0] u;
		if (in[14:7] == 8'hFF) begin
			if (in[6:0] != 0)
				return in | QNAN_BIT;
			return in[15] ? BF_ZERO : BF_INF;
		end
		if (in[14:7] == 0)
			x = real'(in[6:0]) * $bitstoreal({1'b0, 11'd890, 52'd0});
		else
			x = $bitstoreal({1'b0, 11'(int'(in[14:7]) + 896), in[6:0], 45'd0});
		if (in[15])
			x = -x;
		if (x > 89.0)
			return BF_INF;
		if (x < -104.0)
			return BF_ZERO;
		t = x * 1.44269504088896338700e+00;
		k = $rtoi(t + 0.5 + 200.0) - 200;
		r = (x - real'(k) * 6.93147180369123816490e-01)
			- real'(k) * 1.90821492927058770002e-10;
		p = 1.0;
		for (int n = 16; n >= 1; n--)
			p = 1.0 + p * r / real'(n);
		d = p * $bitstoreal(64'(k + 1023) << 52);
		if (d >= $bitstoreal(64'h47EFFFFFF0000000))
			return BF_INF;
		u = to_single(d);
		u = u + 32'h7FFF + ((u >> 16) & 32'd1);
		return u[31:16];
	endfunction

	function automatic exp_word_t predict_word(input bf16_t v);
		exp_word_t w;
		logic      inner_end;
		logic      outer_end;
		inner_end = 17'(inner_idx) + 17'd1 >= 17'((cols_cfg == 0) ? 16'd1 : cols_cfg);
		outer_end = 17'(outer_idx) + 17'd1 >= 17'((rows_cfg == 0) ? 16'd1 : rows_cfg);
		w.result = bf16_exp(v);
		w.last   = inner_end && outer_end;
		if (inner_end) begin
			inner_idx = '0;
			outer_idx = outer_end ? 16'd0 : outer_idx + 16'd1;
		end else begin
			inner_idx = inner_idx + 16'd1;
		end
		return w;
	endfunction

	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall = 1'b1;
			hold_left = hold_left - 1;
		end else begin
			result_stall = ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		exp_word_t w;
		if ((value_valid && !value_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_bf16_exponential_unit: done, errors");
			$finish;
		end
		if (arst_n && result_valid && !result_stall) begin
			words_out++;
			if (pending_q.size() == 0) begin
				$error("unexpected result word %h", result);
				errors++;
			end else begin
				w = pending_q.pop_front();
				if (result !== w.result) begin
					$error("result: expected %h, got %h", w.result, result);
					errors++;
				end
				if (last !== w.last) begin
					$error("last: expected %b, got %b", w.last, last);
					errors++;
				end
				if (w.last)
					lasts_seen++;
			end
		end
	end

	task automatic send_word(input bf16_t v);
		while ($urandom_range(99) < idle_pct) begin
			value_valid = 1'b0;
			@(negedge clk);
		end
		value_valid = 1'b1;
		value = v;
		do
			@(posedge clk);
		while (value_stall);
		pending_q.push_back(predict_word(v));
		words_in++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		value_valid = 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
		wait_drain();
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = {16'h0, data};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx == REG_COLUMNS)
			cols_cfg = data;
		else
			rows_cfg = data;
	endtask

	function automatic bf16_t random_word();
		if ($urandom_range(1))
			return 16'($urandom);
		return {1'($urandom), 8'($urandom_range(8'h7A, 8'h86)), 7'($urandom)};
	endfunction

	task automatic test_special_values();
		bf16_t specials[$] = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7F81,
			16'hFFC1, 16'h7FFF, 16'h0001, 16'h8001, 16'h3F80, 16'hBF80, 16'h7F7F,
			16'hFF7F, 16'h42B1, 16'h42B2, 16'h42B3, 16'hC2CE, 16'hC2D0, 16'hC2D1,
			16'hC2C0, 16'hC2BA, 16'h42B0, 16'h3C00};
		foreach (specials[i])
			send_word(specials[i]);
	endtask

	task automatic test_matrix_counts();
		logic [15:0] sizes[$] = '{16'd0, 16'd0, 16'd3, 16'd2, 16'd1, 16'd5, 16'd4, 16'd1};
		for (int i = 0; i < sizes.size(); i += 2) begin
			write_reg(REG_COLUMNS, sizes[i]);
			write_reg(REG_ROWS, sizes[i + 1]);
			repeat (25) send_word(random_word());
		end
	endtask

	task automatic test_random_stream(input int n, input int idle, input int stall,
			input logic [15:0] cols, input logic [15:0] rows);
		write_reg(REG_COLUMNS, cols);
		write_reg(REG_ROWS, rows);
		idle_pct = idle;
		stall_pct = stall;
		repeat (n) send_word(random_word());
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		hold_left = 200;
		repeat (120) send_word(random_word());
		wait_drain();
		repeat (40) send_word(random_word());
	endtask

	task automatic test_count_change();
		write_reg(REG_COLUMNS, 16'd65535);
		write_reg(REG_ROWS, 16'd65535);
		repeat (30) send_word(random_word());
		write_reg(REG_COLUMNS, 16'd6);
		repeat (20) send_word(random_word());
		write_reg(REG_COLUMNS, 16'd2);
		write_reg(REG_ROWS, 16'd3);
		repeat (20) send_word(random_word());
		write_reg(REG_COLUMNS, 16'd65535);
		write_reg(REG_ROWS, 16'd1);
		repeat (20) send_word(random_word());
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_special_values();
		test_matrix_counts();
		test_backpressure();
		test_random_stream(270, 0, 0, 16'd7, 16'd3);
		test_random_stream(270, 53, 0, 16'd1, 16'd9);
		test_random_stream(270, 0, 53, 16'd13, 16'd2);
		test_random_stream(270, 16, 16, 16'd4, 16'd65535);
		test_count_change();
		wait_drain();
		$display("Sent %0d words, checked %0d results, %0d end-of-matrix flags.",
			words_in, words_out, lasts_seen);
		$display("Covered special values, count settings, backpressure and idle mixes.");
		if (errors == 0)
			$display("tb_bf16_exponential_unit: done, clean");
		else
			$display("tb_bf16_exponential_unit: done, errors");
		$finish;
	end

endmodule

FILE: bf16_exponential_unit.f
hw/rtl/bfe_pkg.sv
hw/rtl/bfe_reduce.sv
hw/rtl/bfe_poly.sv
hw/rtl/bfe_pack.sv
hw/rtl/bf16_exponential_unit.sv
tb/tb_bf16_exponential_unit.sv
